// ===== rtl/signed_integer_to_decimal_text_top_assert.svh =====
// Assertion macros shared by the signed integer to decimal text block.
`ifndef SIGNED_INTEGER_TO_DECIMAL_TEXT_TOP_ASSERT_SVH
`define SIGNED_INTEGER_TO_DECIMAL_TEXT_TOP_ASSERT_SVH

// Check that a condition implies another condition in the same cycle.
`define SITDT_ASSERT_SAME(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |-> (cons)) \
        else $error("sitdt same-cycle check failed");

// Check that a condition implies another condition in the next cycle.
`define SITDT_ASSERT_NEXT(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |=> (cons)) \
        else $error("sitdt next-cycle check failed");

`endif

// ===== rtl/sitdt_pkg.sv =====
// Package with shared constants for the signed integer to decimal text block.
`timescale 1ns / 1ps

package sitdt_pkg;

    // Port width of the input value field
    localparam int VALUE_BITS = 64;
    // Default width of the two's complement integer
    localparam int VALUE_WIDTH_DEFAULT = 64;
    // Width of one output character
    localparam int CHAR_BITS = 8;

    // ASCII codes
    localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 8'd48;
    localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 8'd45;

    // log10(2) as a fraction, for sizing the decimal digit store
    localparam int LOG10_2_NUM = 30103;
    localparam int LOG10_2_DEN = 100000;

endpackage

// ===== rtl/sitdt_value_if.sv =====
// Handshake channel carrying one signed integer per transaction.
`timescale 1ns / 1ps

interface sitdt_value_if;

    logic                                   valid;
    logic                                   ready;
    logic signed [sitdt_pkg::VALUE_BITS-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);

endinterface

// ===== rtl/sitdt_text_if.sv =====
// Handshake channel carrying one text character per transaction.
`timescale 1ns / 1ps

interface sitdt_text_if;

    logic                                valid;
    logic                                ready;
    logic [sitdt_pkg::CHAR_BITS-1:0]     text_char;
    logic                                last_char;

    modport source (output valid, output text_char, output last_char, input ready);
    modport sink   (input valid, input text_char, input last_char, output ready);

endinterface

// ===== rtl/sitdt_dabble.sv =====
// Iterative binary to BCD converter, one magnitude bit per cycle (shift and add 3).
`timescale 1ns / 1ps

module sitdt_dabble #(
    parameter int VALUE_WIDTH = sitdt_pkg::VALUE_WIDTH_DEFAULT,
    parameter int NUM_DIGITS  = 19
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [VALUE_WIDTH-1:0]    mag,
    output logic                      done,
    output logic [NUM_DIGITS*4-1:0]   bcd
);

    localparam int BCD_W = NUM_DIGITS * 4;
    localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

    logic [VALUE_WIDTH-1:0] bin_reg;
    logic [VALUE_WIDTH-1:0] bin_next;
    logic [BCD_W-1:0]       bcd_reg;
    logic [BCD_W-1:0]       bcd_next;
    logic [BCD_W-1:0]       bcd_adj;
    logic [CNT_W-1:0]       cnt_reg;
    logic [CNT_W-1:0]       cnt_next;
    logic                   busy_reg;
    logic                   busy_next;
    logic                   done_reg;
    logic                   done_next;

    // Add 3 to every digit of 5 or more before the shift
    always_comb
    begin
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (bcd_reg[i*4 +: 4] >= 4'd5)
            begin
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4] + 4'd3;
            end
            else
            begin
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4];
            end
        end
    end

    // Load on start, then shift one bit per cycle until the count runs out
    always_comb
    begin
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            bin_next  = mag;
            bcd_next  = '0;
            cnt_next  = CNT_W'(VALUE_WIDTH);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            bcd_next = {bcd_adj[BCD_W-2:0], bin_reg[VALUE_WIDTH-1]};
            bin_next = {bin_reg[VALUE_WIDTH-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Hold converter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_reg  <= '0;
            bcd_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            bin_reg  <= bin_next;
            bcd_reg  <= bcd_next;
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done = done_reg;
    assign bcd  = bcd_reg;

endmodule

// ===== rtl/signed_integer_to_decimal_text_top.sv =====
// Top level: signed integer in, its decimal ASCII text out one character per transaction.
//
// Usage:
//   num  (sink)   : one signed integer per transaction; the low VALUE_WIDTH bits of
//                   value are the two's complement number, upper bits are ignored.
//   text (source) : the decimal text, one character per transaction: '-' first for a
//                   negative number, then digits most significant first with no
//                   leading zeros; zero gives '0'. last_char marks the final character.
//   Conversion: the magnitude is converted to BCD by a shift-and-add-3 loop that takes
//   one bit per cycle. The digit stage then skips each leading zero and emits each
//   digit in turn, after a '-' for a negative number.
//   The block takes no new number until it is through with the current one;
//   num.ready is high only while the block is idle.
//   Characters leave through an output register: when text.ready is low the current
//   character holds and the next character waits. The next number is taken as soon as
//   the previous number's final character sits in the output register.
//   Reset (rst_n low, asynchronous) empties the output register and returns the
//   sequencer to idle; no state is kept between numbers.
`timescale 1ns / 1ps
`include "signed_integer_to_decimal_text_top_assert.svh"

module signed_integer_to_decimal_text_top #(
    parameter int VALUE_WIDTH = sitdt_pkg::VALUE_WIDTH_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    sitdt_value_if.sink          num,
    sitdt_text_if.source         text
);

    localparam int NUM_DIGITS = ((VALUE_WIDTH - 1) * sitdt_pkg::LOG10_2_NUM)
                                / sitdt_pkg::LOG10_2_DEN + 1;
    localparam int BCD_W      = NUM_DIGITS * 4;
    localparam int IDX_W      = $clog2(NUM_DIGITS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_SIGN,
        ST_DIGITS
    } state_t;

    state_t                          state_reg;
    state_t                          state_next;
    logic                            neg_reg;
    logic                            neg_next;
    logic [BCD_W-1:0]                digits_reg;
    logic [BCD_W-1:0]                digits_next;
    logic [IDX_W-1:0]                idx_reg;
    logic [IDX_W-1:0]                idx_next;
    logic                            started_reg;
    logic                            started_next;
    logic                            out_valid_reg;
    logic                            out_valid_next;
    logic [sitdt_pkg::CHAR_BITS-1:0] out_char_reg;
    logic [sitdt_pkg::CHAR_BITS-1:0] out_char_next;
    logic                            out_last_reg;
    logic                            out_last_next;

    logic [VALUE_WIDTH-1:0]          raw_val;
    logic [VALUE_WIDTH-1:0]          mag;
    logic                            accept;
    logic                            out_free;
    logic [3:0]                      top_digit;
    logic                            dab_done;
    logic [BCD_W-1:0]                dab_bcd;

    // Form the unsigned magnitude of the incoming value
    assign raw_val = num.value[VALUE_WIDTH-1:0];
    assign mag     = raw_val[VALUE_WIDTH-1] ? VALUE_WIDTH'(~raw_val + 1'b1) : raw_val;

    assign num.ready = (state_reg == ST_IDLE);
    assign accept    = num.valid && num.ready;
    assign out_free  = !out_valid_reg || text.ready;
    assign top_digit = digits_reg[BCD_W-1 -: 4];

    sitdt_dabble #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .NUM_DIGITS  (NUM_DIGITS)
    ) u_dabble (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept),
        .mag   (mag),
        .done  (dab_done),
        .bcd   (dab_bcd)
    );

    // Sequence sign and digits into the output register
    always_comb
    begin
        state_next     = state_reg;
        neg_next       = neg_reg;
        digits_next    = digits_reg;
        idx_next       = idx_reg;
        started_next   = started_reg;
        out_valid_next = out_valid_reg && !text.ready;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    neg_next   = raw_val[VALUE_WIDTH-1];
                    state_next = ST_CONVERT;
                end
            end
            ST_CONVERT:
            begin
                if (dab_done)
                begin
                    digits_next  = dab_bcd;
                    idx_next     = IDX_W'(NUM_DIGITS - 1);
                    started_next = 1'b0;
                    state_next   = neg_reg ? ST_SIGN : ST_DIGITS;
                end
            end
            ST_SIGN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = sitdt_pkg::CHAR_MINUS;
                    out_last_next  = 1'b0;
                    state_next     = ST_DIGITS;
                end
            end
            ST_DIGITS:
            begin
                if (!started_reg && top_digit == 4'd0 && idx_reg != '0)
                begin
                    // Drop a leading zero
                    digits_next = {digits_reg[BCD_W-5:0], 4'd0};
                    idx_next    = idx_reg - 1'b1;
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = sitdt_pkg::CHAR_ZERO + {4'd0, top_digit};
                    out_last_next  = (idx_reg == '0);
                    digits_next    = {digits_reg[BCD_W-5:0], 4'd0};
                    idx_next       = idx_reg - 1'b1;
                    started_next   = 1'b1;
                    if (idx_reg == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold sequencer state and the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            neg_reg       <= 1'b0;
            digits_reg    <= '0;
            idx_reg       <= '0;
            started_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            out_char_reg  <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            neg_reg       <= neg_next;
            digits_reg    <= digits_next;
            idx_reg       <= idx_next;
            started_reg   <= started_next;
            out_valid_reg <= out_valid_next;
            out_char_reg  <= out_char_next;
            out_last_reg  <= out_last_next;
        end
    end

    assign text.valid     = out_valid_reg;
    assign text.text_char = out_char_reg;
    assign text.last_char = out_last_reg;

    // An accepted number always starts a conversion
    `SITDT_ASSERT_NEXT(a_accept_converts, clk, rst_n, accept, state_reg == ST_CONVERT)
    // The converter only finishes while the sequencer waits for it
    `SITDT_ASSERT_SAME(a_done_in_convert, clk, rst_n, dab_done, state_reg == ST_CONVERT)
    // A sign never ends a number's text
    `SITDT_ASSERT_SAME(a_sign_not_last, clk, rst_n,
        text.valid && text.text_char == sitdt_pkg::CHAR_MINUS, !text.last_char)
    // Loading the final digit returns the sequencer to idle
    `SITDT_ASSERT_NEXT(a_last_to_idle, clk, rst_n,
        state_reg == ST_DIGITS && out_free && started_reg && idx_reg == '0,
        state_reg == ST_IDLE && out_last_reg)

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the signed integer to decimal text block.
`timescale 1ns / 1ps

module tb_top;

    localparam int TB_WIDTH       = sitdt_pkg::VALUE_WIDTH_DEFAULT;
    localparam int MAX_CHARS      = 20;
    localparam int HOLD_CYCLES    = 400;
    localparam int QUIET_LIMIT    = 4000;
    localparam int DRAIN_CYCLES   = 120;
    localparam int PHASE_ITEMS    = 95;

    typedef struct packed {
        logic [sitdt_pkg::CHAR_BITS-1:0] text_char;
        logic                            last_char;
    } text_item_t;

    logic clk;
    logic rst_n;

    sitdt_value_if num_ch ();
    sitdt_text_if  text_ch ();

    signed_integer_to_decimal_text_top #(
        .VALUE_WIDTH (TB_WIDTH)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .num   (num_ch),
        .text  (text_ch)
    );

    text_item_t expected_text [$];
    int         mismatches;
    int         send_idle_pct;
    int         recv_stall_pct;
    bit         hold_req;
    int         held;
    int         quiet_cycles;

    // Free-running clock, 8 ns period
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Work out the characters one number should produce and queue them
    function automatic void predict_text(input logic [sitdt_pkg::VALUE_BITS-1:0] raw);
        logic [sitdt_pkg::VALUE_BITS-1:0] mask;
        logic [sitdt_pkg::VALUE_BITS-1:0] word;
        logic [sitdt_pkg::VALUE_BITS-1:0] magnitude;
        logic [sitdt_pkg::CHAR_BITS-1:0]  digit_buf [0:MAX_CHARS-1];
        logic                             negative;
        int                               ndig;
        mask = {sitdt_pkg::VALUE_BITS{1'b1}} >> (sitdt_pkg::VALUE_BITS - TB_WIDTH);
        word = raw & mask;
        negative = word[TB_WIDTH-1];
        magnitude = negative ? ((~word + 64'd1) & mask) : word;
        ndig = 0;
        do
        begin
            digit_buf[ndig] = sitdt_pkg::CHAR_ZERO
                              + sitdt_pkg::CHAR_BITS'(magnitude % 64'd10);
            ndig++;
            magnitude = magnitude / 64'd10;
        end
        while (magnitude != 0 && ndig < MAX_CHARS);
        if (negative)
            expected_text.push_back('{sitdt_pkg::CHAR_MINUS, 1'b0});
        for (int k = ndig - 1; k >= 0; k--)
            expected_text.push_back('{digit_buf[k], k == 0});
    endfunction

    function automatic logic [sitdt_pkg::VALUE_BITS-1:0] ten_to(input int k);
        logic [sitdt_pkg::VALUE_BITS-1:0] acc;
        acc = 64'd1;
        for (int i = 0; i < k; i++)
            acc = acc * 64'd10;
        return acc;
    endfunction

    // Pick a number: full range, a random digit count, a decade edge, or a small one
    function automatic logic [sitdt_pkg::VALUE_BITS-1:0] random_value();
        logic [sitdt_pkg::VALUE_BITS-1:0] mag;
        logic                             flip;
        flip = $urandom_range(1);
        case ($urandom_range(3))
            0: return {$urandom, $urandom};
            1: mag = {$urandom, $urandom} % ten_to($urandom_range(1, 18));
            2: mag = ten_to($urandom_range(0, 18)) - 64'($urandom_range(1));
            default: mag = 64'($urandom_range(1000));
        endcase
        return flip ? -mag : mag;
    endfunction

    // Offer one number, optionally after an idle gap, and hold it until taken
    task automatic send_value(input logic [sitdt_pkg::VALUE_BITS-1:0] v);
        if ($urandom_range(99) < send_idle_pct)
        begin
            num_ch.valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        num_ch.valid <= 1'b1;
        num_ch.value <= v;
        @(posedge clk);
        while (!num_ch.ready)
            @(posedge clk);
        predict_text(v);
    endtask

    // Extremes, decade edges, zero and the most negative value
    task automatic test_directed_values();
        logic [sitdt_pkg::VALUE_BITS-1:0] picks [$];
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        picks = '{
            64'd0, 64'd1, -64'sd1, 64'd9, 64'd10, -64'sd10, 64'd99, 64'd100,
            -64'sd7, 64'd12345, 64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
            64'h8000_0000_0000_0001, 64'd999999999999999999,
            64'd1000000000000000000, -64'sd1000000000000000000,
            64'h0000_0000_8000_0000, -64'sd4294967296, 64'hAAAA_AAAA_AAAA_AAAA,
            64'h5555_5555_5555_5555
        };
        foreach (picks[i])
            send_value(picks[i]);
    endtask

    task automatic test_random_values(input int idle_pct, input int stall_pct, input int count);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count)
            send_value(random_value());
    endtask

    // Hold off the text side long enough that the block stops taking numbers
    task automatic test_long_hold();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        @(negedge clk);
        hold_req = 1'b1;
        @(posedge clk);
        repeat (5)
            send_value(random_value());
        while (hold_req)
            @(posedge clk);
    endtask

    // Text side ready, with random stalls and the long hold on request
    initial
    begin
        text_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                for (held = 0; held < HOLD_CYCLES; held++)
                begin
                    text_ch.ready <= 1'b0;
                    @(posedge clk);
                end
                hold_req = 1'b0;
            end
            text_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Compare each character that leaves with the oldest one expected
    always @(posedge clk)
    begin
        text_item_t want;
        if (rst_n && text_ch.valid && text_ch.ready)
        begin
            if (expected_text.size() == 0)
            begin
                $display("%0t: unexpected character %0d last %0b", $time,
                         text_ch.text_char, text_ch.last_char);
                mismatches++;
            end
            else
            begin
                want = expected_text.pop_front();
                if (text_ch.text_char !== want.text_char)
                begin
                    $display("%0t: text_char expected %0d got %0d", $time,
                             want.text_char, text_ch.text_char);
                    mismatches++;
                end
                if (text_ch.last_char !== want.last_char)
                begin
                    $display("%0t: last_char expected %0b got %0b", $time,
                             want.last_char, text_ch.last_char);
                    mismatches++;
                end
            end
        end
    end

    // End the run if nothing moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((num_ch.valid && num_ch.ready) || (text_ch.valid && text_ch.ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("FAIL signed_integer_to_decimal_text_top");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        mismatches     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req       = 1'b0;
        quiet_cycles   = 0;
        rst_n          <= 1'b0;
        num_ch.valid   <= 1'b0;
        num_ch.value   <= '0;
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_values();
        test_random_values(0, 0, PHASE_ITEMS);
        test_random_values(52, 0, PHASE_ITEMS);
        test_random_values(0, 52, PHASE_ITEMS);
        test_random_values(24, 24, PHASE_ITEMS);
        test_long_hold();
        num_ch.valid <= 1'b0;

        // Drain the remaining text, then allow for the block's latency
        while (expected_text.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        if (mismatches == 0 && expected_text.size() == 0)
            $display("PASS signed_integer_to_decimal_text_top");
        else
            $display("FAIL signed_integer_to_decimal_text_top");
        $finish;
    end

endmodule
